// ===== src/arc_cache_replacement_core_macros.svh =====
// Assertion macros shared by the cache replacement core.
// Both expect signals named clk and rst in the module that uses them.
`ifndef ARC_CACHE_REPLACEMENT_CORE_MACROS_SVH
`define ARC_CACHE_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ARC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/arc_pkg.sv =====
// Shared types and constants of the adaptive replacement cache directory.
// No dependencies; used by the top level.
package arc_pkg;

  localparam int KEY_BITS  = 32;
  localparam int DATA_BITS = 32;
  localparam int CAP_BITS  = 9;

  // Operation codes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  // List codes.
  localparam logic [1:0] L_T1 = 2'd0;
  localparam logic [1:0] L_T2 = 2'd1;
  localparam logic [1:0] L_B1 = 2'd2;
  localparam logic [1:0] L_B2 = 2'd3;

  // Location codes reported in found_in.
  localparam logic [2:0] FOUND_NONE = 3'd0;

  typedef struct packed {
    logic                 cmd;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [DATA_BITS-1:0] read_value;
    logic [2:0]           found_in;
  } rsp_t;

endpackage

// ===== src/arc_div.sv =====
// Restoring divider for the ratio of ghost list lengths, one quotient bit per cycle.
// Stand-alone; instantiated by the cache replacement core.
module arc_div #(
  parameter int NW = 18,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   shreg;
  logic [DW-1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     trial;
  logic            qbit;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem, shreg[NW-1]};
    qbit  = (trial >= {1'b0, den});
  end

  // The numerator shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNTW'(NW);
        rem   <= '0;
        shreg <= num;
      end else if (busy) begin
        rem   <= qbit ? DW'(trial - {1'b0, den}) : DW'(trial);
        shreg <= {shreg[NW-2:0], qbit};
        cnt   <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = shreg;

endmodule

// ===== src/arc_cache_replacement_core.sv =====
// Adaptive replacement cache directory: T1/T2 resident and B1/B2 ghost lists.
// Depends on arc_pkg, arc_div and the assertion macro header.
//
// Every request gives exactly one response. After reset the directory runs a
// clearing pass over all slots before it takes its first request; capacity
// writes are taken at any time. With capacity 0 the request goes straight to
// the response step. Otherwise the key is found by scanning the key memory
// one slot per cycle. Each list move unlinks the slot and pushes it onto the
// head of its new list. A ghost hit first adapts the target, waiting for the
// divider when the ratio has to be divided. One request is processed at a
// time; a finished response may wait in its output register while the next
// request is taken.
`include "arc_cache_replacement_core_macros.svh"

module arc_cache_replacement_core #(
  parameter int MAX_CAPACITY = 256,
  parameter int P_FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  arc_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output arc_pkg::rsp_t                rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [arc_pkg::CAP_BITS-1:0] cfg_data
);

  import arc_pkg::*;

  localparam int SLOTS = 2 * MAX_CAPACITY;
  localparam int SW    = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int CW    = $clog2(MAX_CAPACITY + 1);
  localparam int EW    = ((CW > CAP_BITS) ? CW : CAP_BITS) + 1;
  localparam int QW    = LW + P_FRAC_BITS;
  localparam int PW    = CW + P_FRAC_BITS;
  localparam int WW    = ((LW > CW) ? LW : CW) + P_FRAC_BITS + 3;
  localparam int KW    = KEY_BITS + 1;
  localparam int DTW   = DATA_BITS + 1;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);
  localparam logic [CAP_BITS-1:0] CAP_RESET =
    (MAX_CAPACITY < 256) ? CAP_BITS'(MAX_CAPACITY) : CAP_BITS'(256);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_SCAN, S_LOOK, S_LOOK2, S_ADAPT, S_DIVW, S_APPLY,
    S_REPL, S_UN0, S_UN1, S_PU0, S_PU1, S_ACC, S_TRIM, S_TREPL, S_DROP,
    S_INS0, S_INS1, S_OUT
  } state_t;

  state_t ret;
  state_t state;

  // Control and bookkeeping registers.
  logic [CAP_BITS-1:0] cap_reg;
  logic [SW-1:0]       clr;
  logic [LW-1:0]       scan_cnt;
  logic                scan_pend;
  logic [SW-1:0]       slot;
  logic [SW-1:0]       op_s;
  logic [1:0]          op_l;
  logic                push_after;
  logic                in_b2;
  logic [1:0]          hit_list;
  logic [QW-1:0]       delta;
  logic [PW-1:0]       p;
  logic [LW-1:0]       free_top;
  logic [SW-1:0]       list_head [4];
  logic [SW-1:0]       list_tail [4];
  logic [LW-1:0]       list_len  [4];
  logic                cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [DATA_BITS-1:0] val_r;
  rsp_t                res;

  // Memories and their registered read data.
  logic [KW-1:0]  key_mem  [SLOTS];
  logic [DTW-1:0] data_mem [SLOTS];
  logic [1:0]     list_mem [SLOTS];
  logic [LW-1:0]  prev_mem [SLOTS];
  logic [LW-1:0]  next_mem [SLOTS];
  logic [SW-1:0]  free_mem [SLOTS];
  logic [KW-1:0]  key_q;
  logic [DTW-1:0] data_q;
  logic [1:0]     list_q;
  logic [LW-1:0]  prev_q;
  logic [LW-1:0]  next_q;
  logic [SW-1:0]  free_q;

  logic           key_we, data_we, list_we, prev_we, next_we, free_we;
  logic [SW-1:0]  key_wa, data_wa, list_wa, prev_wa, next_wa, free_wa;
  logic [KW-1:0]  key_wd;
  logic [DTW-1:0] data_wd;
  logic [1:0]     list_wd;
  logic [LW-1:0]  prev_wd, next_wd;
  logic [SW-1:0]  free_wd;
  logic [SW-1:0]  link_ra;

  // Derived values.
  logic [EW-1:0] eff_w;
  logic [CW-1:0] eff_cap;
  logic          req_xfer;
  logic          key_match;
  logic          pick_t1, ev_go;
  logic [1:0]    ev_from, ev_to;
  logic [WW-1:0] t1w, t2w, b1w, b2w, capw, t1fix, pw, sum_len;
  logic [LW-1:0] num_len, den_len;
  logic          need_div;
  logic          div_start, div_done;
  logic [QW-1:0] div_num, div_quot;
  logic [WW-1:0] p_sum, p_lim;
  logic [1:0]    un_l;

  // Capacity above the directory size acts as the directory size.
  always_comb begin
    eff_w   = (EW'(cap_reg) > EW'(MAX_CAPACITY)) ? EW'(MAX_CAPACITY) : EW'(cap_reg);
    eff_cap = CW'(eff_w);
  end

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign key_match = scan_pend && key_q[KW-1] && (key_q[KEY_BITS-1:0] == key_r);
  assign un_l      = list_q;

  // List sizes in a common wide format for the policy compares.
  always_comb begin
    t1w     = WW'(list_len[L_T1]);
    t2w     = WW'(list_len[L_T2]);
    b1w     = WW'(list_len[L_B1]);
    b2w     = WW'(list_len[L_B2]);
    capw    = WW'(eff_cap);
    pw      = WW'(p);
    t1fix   = t1w << P_FRAC_BITS;
    sum_len = t1w + t2w + b1w + b2w;
  end

  // Replacement choice: T1 tail to B1, or T2 tail to B2.
  always_comb begin
    pick_t1 = (list_len[L_T1] != '0) && ((t1fix > pw) || (in_b2 && (t1fix == pw)));
    if (!pick_t1 && (list_len[L_T2] == '0)) begin
      pick_t1 = 1'b1;
    end
    ev_from = pick_t1 ? L_T1 : L_T2;
    ev_to   = pick_t1 ? L_B1 : L_B2;
    ev_go   = !pick_t1 || (list_len[L_T1] != '0);
  end

  // Adaptation step: ratio of the ghost list lengths when it exceeds one.
  always_comb begin
    if (hit_list == L_B1) begin
      num_len  = list_len[L_B2];
      den_len  = list_len[L_B1];
    end else begin
      num_len  = list_len[L_B1];
      den_len  = list_len[L_B2];
    end
    need_div  = !((den_len >= num_len) || (den_len == '0));
    div_num   = QW'(num_len) << P_FRAC_BITS;
    div_start = (state == S_ADAPT) && need_div;
    p_sum     = pw + WW'(delta);
    p_lim     = capw << P_FRAC_BITS;
  end

  arc_div #(
    .NW (QW),
    .DW (LW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den_len),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Memory write controls per sequencer step.
  always_comb begin
    key_we  = 1'b0; key_wa  = '0; key_wd  = '0;
    data_we = 1'b0; data_wa = '0; data_wd = '0;
    list_we = 1'b0; list_wa = '0; list_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    free_we = 1'b0; free_wa = '0; free_wd = '0;
    unique case (state)
      S_CLR: begin
        key_we  = 1'b1;
        key_wa  = clr;
        free_we = 1'b1;
        free_wa = clr;
        free_wd = SW'(SLOTS - 1) - clr;
      end
      S_LOOK2: begin
        if (cmd_r == CMD_SET) begin
          data_we = 1'b1;
          data_wa = slot;
          data_wd = {1'b1, val_r};
        end
      end
      S_REPL: begin
        if (ev_go) begin
          data_we = 1'b1;
          data_wa = list_tail[ev_from];
        end
      end
      S_UN1: begin
        if (prev_q != NIL) begin
          next_we = 1'b1;
          next_wa = prev_q[SW-1:0];
          next_wd = next_q;
        end
        if (next_q != NIL) begin
          prev_we = 1'b1;
          prev_wa = next_q[SW-1:0];
          prev_wd = prev_q;
        end
      end
      S_PU0: begin
        list_we = 1'b1;
        list_wa = op_s;
        list_wd = op_l;
        next_we = 1'b1;
        next_wa = op_s;
        next_wd = (list_len[op_l] != '0) ? LW'(list_head[op_l]) : NIL;
        if (list_len[op_l] != '0) begin
          prev_we = 1'b1;
          prev_wa = list_head[op_l];
          prev_wd = LW'(op_s);
        end
      end
      S_PU1: begin
        prev_we = 1'b1;
        prev_wa = op_s;
        prev_wd = NIL;
      end
      S_DROP: begin
        if (list_len[op_l] != '0) begin
          key_we = 1'b1;
          key_wa = list_tail[op_l];
          if (free_top < LW'(SLOTS)) begin
            free_we = 1'b1;
            free_wa = free_top[SW-1:0];
            free_wd = list_tail[op_l];
          end
        end
      end
      S_INS1: begin
        key_we  = 1'b1;
        key_wa  = free_q;
        key_wd  = {1'b1, key_r};
        data_we = 1'b1;
        data_wa = free_q;
        data_wd = {1'b1, val_r};
      end
      default: begin
      end
    endcase
  end

  assign link_ra = (state == S_LOOK) ? slot : op_s;

  // Directory memories: one write and one registered read each. Every read is
  // issued in a step of its own after the writes it depends on, so no
  // forwarding is needed.
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_q <= key_mem[scan_cnt[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_wa] <= data_wd;
    data_q <= data_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    list_q <= list_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_q <= prev_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_q <= next_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_q <= free_mem[SW'(free_top - 1'b1)];
  end

  // Sequencer: lookup, adaptation, list surgery and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      ret       <= S_OUT;
      cap_reg   <= CAP_RESET;
      clr       <= '0;
      scan_cnt  <= '0;
      scan_pend <= 1'b0;
      free_top  <= LW'(SLOTS);
      p         <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        list_len[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        cap_reg <= cfg_data;
      end
      // The response step reloads the register itself when it is freed.
      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == SW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_xfer) begin
            cmd_r     <= req.cmd;
            key_r     <= req.key;
            val_r     <= req.data_value;
            res       <= '0;
            scan_cnt  <= '0;
            scan_pend <= 1'b0;
            state     <= (eff_cap == '0) ? S_OUT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (key_match) begin
            slot  <= SW'(scan_cnt - 1'b1);
            state <= S_LOOK;
          end else if (scan_cnt == LW'(SLOTS)) begin
            res.found_in <= FOUND_NONE;
            state        <= (cmd_r == CMD_SET) ? S_TRIM : S_OUT;
          end else begin
            scan_cnt  <= scan_cnt + 1'b1;
            scan_pend <= 1'b1;
          end
        end
        S_LOOK: begin
          state <= S_LOOK2;
        end
        S_LOOK2: begin
          hit_list     <= list_q;
          res.found_in <= {1'b0, list_q} + 3'd1;
          if (cmd_r == CMD_GET && data_q[DTW-1]) begin
            res.hit        <= 1'b1;
            res.read_value <= data_q[DATA_BITS-1:0];
          end
          state <= (list_q == L_B1 || list_q == L_B2) ? S_ADAPT : S_ACC;
        end
        S_ADAPT: begin
          delta <= QW'(1) << P_FRAC_BITS;
          state <= need_div ? S_DIVW : S_APPLY;
        end
        S_DIVW: begin
          if (div_done) begin
            delta <= div_quot;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (hit_list == L_B1) begin
            p     <= (p_sum > p_lim) ? PW'(p_lim) : PW'(p_sum);
            in_b2 <= 1'b0;
          end else begin
            p     <= (pw > WW'(delta)) ? PW'(pw - WW'(delta)) : '0;
            in_b2 <= 1'b1;
          end
          ret   <= S_ACC;
          state <= S_REPL;
        end
        S_REPL: begin
          if (ev_go) begin
            op_s       <= list_tail[ev_from];
            op_l       <= ev_to;
            push_after <= 1'b1;
            state      <= S_UN0;
          end else begin
            state <= ret;
          end
        end
        S_UN0: begin
          state <= S_UN1;
        end
        S_UN1: begin
          if (prev_q == NIL) list_head[un_l] <= next_q[SW-1:0];
          if (next_q == NIL) list_tail[un_l] <= prev_q[SW-1:0];
          if (list_len[un_l] != '0) list_len[un_l] <= list_len[un_l] - 1'b1;
          state <= push_after ? S_PU0 : ret;
        end
        S_PU0: begin
          state <= S_PU1;
        end
        S_PU1: begin
          if (list_len[op_l] == '0) list_tail[op_l] <= op_s;
          list_head[op_l] <= op_s;
          list_len[op_l]  <= list_len[op_l] + 1'b1;
          state           <= ret;
        end
        S_ACC: begin
          op_s       <= slot;
          op_l       <= L_T2;
          push_after <= 1'b1;
          ret        <= S_OUT;
          state      <= S_UN0;
        end
        S_TRIM: begin
          if (t1w + b1w >= capw) begin
            if (t1w < capw) begin
              op_l <= L_B1;
              ret  <= S_TREPL;
            end else begin
              op_l <= L_T1;
              ret  <= S_INS0;
            end
            state <= S_DROP;
          end else if (sum_len >= capw) begin
            if (sum_len >= (capw << 1)) begin
              op_l  <= L_B2;
              ret   <= S_TREPL;
              state <= S_DROP;
            end else begin
              state <= S_TREPL;
            end
          end else begin
            state <= S_INS0;
          end
        end
        S_TREPL: begin
          in_b2 <= 1'b0;
          ret   <= S_INS0;
          state <= S_REPL;
        end
        S_DROP: begin
          if (list_len[op_l] == '0) begin
            state <= ret;
          end else begin
            if (free_top < LW'(SLOTS)) free_top <= free_top + 1'b1;
            op_s       <= list_tail[op_l];
            push_after <= 1'b0;
            state      <= S_UN0;
          end
        end
        S_INS0: begin
          // The free-stack read at top-1 is issued in this step.
          if (free_top == '0) begin
            state <= S_OUT;
          end else begin
            free_top <= free_top - 1'b1;
            state    <= S_INS1;
          end
        end
        S_INS1: begin
          op_s  <= free_q;
          op_l  <= L_T1;
          ret   <= S_OUT;
          state <= S_PU0;
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Every slot is either in one list or on the free stack between requests.
  `ARC_ASSERT_IMP(a_slot_count, state == S_IDLE, sum_len + WW'(free_top) == WW'(SLOTS), "slot accounting broken")
  // The target never exceeds the largest capacity.
  `ARC_ASSERT_IMP(a_p_bound, 1'b1, pw <= (WW'(MAX_CAPACITY) << P_FRAC_BITS), "target p out of range")
  // A quotient only arrives while the sequencer waits for it.
  `ARC_ASSERT_IMP(a_div_owner, div_done, state == S_DIVW, "stray divider result")
  // A finished response reaches the output register when it is free.
  `ARC_ASSERT_NXT(a_rsp_load, state == S_OUT && !(rsp_valid && rsp_stall), rsp_valid && state == S_IDLE, "response not loaded")

endmodule
